// ===== rtl/set_assoc_lru_cache_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache filter
// Shorthand for clocked assertions on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_FILTER_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("salc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("salc assertion failed");

`endif

// ===== rtl/salc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Sizes, row formats, command and status types and index helpers shared by
// the controller, the datapath and the top level of the cache filter.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int CORES  = 8;
    localparam int SETS   = 64;   // A power of two: the set is the low address bits.
    localparam int WAYS   = 8;

    localparam int ADDR_W = 64;
    localparam int IN_CORE_W = 3;
    localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int SET_W  = $clog2(SETS);
    localparam int TAG_W  = ADDR_W - SET_W;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int RANK_W = $clog2(WAYS);
    localparam int ROWS   = CORES * SETS;
    localparam int ROW_W  = $clog2(ROWS);

    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [WAY_W-1:0]  way_t;
    typedef logic [CORE_W-1:0] core_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef tag_t [WAYS-1:0] tag_row_t;

    typedef struct packed {
        logic [WAYS-1:0]  valid;
        rank_t [WAYS-1:0] rank;
    } set_state_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } salc_state_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic clear_we;
        row_t clear_row;
    } salc_cmd_t;

    typedef struct packed {
        logic miss;
        logic out_busy;
    } salc_stat_t;

    function automatic core_t reduce_core(logic [IN_CORE_W-1:0] c);
        core_t r;
        r = '0;
        for (int i = 0; i < (1 << IN_CORE_W); i++) begin
            if (c == IN_CORE_W'(i)) begin
                r = CORE_W'(i % CORES);
            end
        end
        return r;
    endfunction

    function automatic row_t row_index(core_t c, logic [ADDR_W-1:0] addr);
        row_t base;
        base = ROW_W'(ROW_W'(c) * ROW_W'(SETS));
        return row_t'(base + ROW_W'(addr[SET_W-1:0]));
    endfunction

    function automatic set_state_t reset_state();
        set_state_t s;
        s.valid = '0;
        for (int i = 0; i < WAYS; i++) begin
            s.rank[i] = RANK_W'(i);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/salc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// salc_ctrl
// Controller: runs the clearing pass over the set state after reset, then
// alternates between taking a request and committing its lookup.
// ----------------------------------------------------------------------------
module salc_ctrl
    import salc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire salc_stat_t stat,
    output salc_cmd_t       cmd
);

    salc_state_t state_reg, state_next;
    row_t        clear_cnt_reg, clear_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.clear_row  = clear_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_we   = 1'b1;
                clear_cnt_next = row_t'(clear_cnt_reg + 1'b1);
                if (clear_cnt_reg == ROW_W'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!(stat.miss && stat.out_busy)) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/salc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// salc_datapath
// Tag and set-state memories, way compare, victim choice, rank update and
// the miss output register.
// ----------------------------------------------------------------------------
module salc_datapath
    import salc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [IN_CORE_W-1:0]  s_core,
    input  wire logic [ADDR_W-1:0]     s_block_address,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [IN_CORE_W-1:0]       m_miss_core,
    output logic [ADDR_W-1:0]          m_miss_block_address,
    input  wire salc_cmd_t             cmd,
    output salc_stat_t                 stat
);

    tag_row_t   tag_mem [ROWS];
    set_state_t st_mem  [ROWS];

    tag_row_t          rd_tag_reg;
    set_state_t        rd_st_reg;
    core_t             core_reg;
    logic [ADDR_W-1:0] addr_reg;
    row_t              row_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [IN_CORE_W-1:0]  miss_core_reg;
    logic [ADDR_W-1:0]     miss_addr_reg;

    core_t      in_core;
    row_t       rd_row;
    tag_t       cur_tag;
    logic       hit;
    way_t       hit_way;
    logic       all_valid;
    way_t       inv_way;
    way_t       victim;
    rank_t      best;
    way_t       sel_way;
    rank_t      sel_rank;
    set_state_t st_wdata;
    row_t       st_waddr;
    logic       st_we;
    tag_row_t   tag_wdata;
    logic       tag_we;

    assign in_core = reduce_core(s_core);
    assign rd_row  = row_index(in_core, s_block_address);
    assign cur_tag = addr_reg[ADDR_W-1:SET_W];

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        all_valid = 1'b1;
        inv_way   = '0;
        victim    = '0;
        best      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && rd_st_reg.valid[w] && rd_tag_reg[w] == cur_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (all_valid && !rd_st_reg.valid[w]) begin
                all_valid = 1'b0;
                inv_way   = WAY_W'(w);
            end
            if (rd_st_reg.rank[w] >= best) begin
                best   = rd_st_reg.rank[w];
                victim = WAY_W'(w);
            end
        end
        if (hit) begin
            sel_way = hit_way;
        end else if (!all_valid) begin
            sel_way = inv_way;
        end else begin
            sel_way = victim;
        end
    end

    always_comb begin
        st_wdata  = rd_st_reg;
        tag_wdata = rd_tag_reg;
        sel_rank  = rd_st_reg.rank[sel_way];
        for (int j = 0; j < WAYS; j++) begin
            if (rd_st_reg.rank[j] < sel_rank) begin
                st_wdata.rank[j] = rank_t'(rd_st_reg.rank[j] + 1'b1);
            end
        end
        st_wdata.rank[sel_way]  = '0;
        st_wdata.valid[sel_way] = 1'b1;
        tag_wdata[sel_way]      = cur_tag;
        if (cmd.clear_we) begin
            st_wdata = reset_state();
        end
    end

    assign st_we    = cmd.clear_we || cmd.commit;
    assign st_waddr = cmd.clear_we ? cmd.clear_row : row_reg;
    assign tag_we   = cmd.commit && !hit;

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[row_reg] <= tag_wdata;
        end
        if (cmd.load) begin
            rd_tag_reg <= tag_mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (cmd.load) begin
            rd_st_reg <= st_mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            core_reg <= in_core;
            addr_reg <= s_block_address;
            row_reg  <= rd_row;
        end
        if (cmd.commit && !hit) begin
            miss_core_reg <= IN_CORE_W'(core_reg);
            miss_addr_reg <= addr_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit && !hit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign stat.miss     = !hit;
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign m_valid              = m_valid_reg;
    assign m_miss_core          = miss_core_reg;
    assign m_miss_block_address = miss_addr_reg;

endmodule
`default_nettype wire

// ===== rtl/set_assoc_lru_cache_filter.sv =====
// The accept edge reads the set row from the tag and set-state memories, and
// the lookup state then compares all ways, updates the ranks and writes the row
// back. No new request is taken until the current lookup commits.
// A miss result is registered as the lookup commits; a full output holds the
// write-back of a miss. After reset a clearing pass runs over all CORES*SETS (512)
// rows of the set-state memory, during which no request is accepted.
`default_nettype none
`include "set_assoc_lru_cache_filter_defines.svh"
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_filter
// Per-core set-associative tag store with LRU replacement that passes each
// missing request on to the next level.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_filter
    import salc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [IN_CORE_W-1:0]  s_core,
    input  wire logic [ADDR_W-1:0]     s_block_address,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [IN_CORE_W-1:0]       m_miss_core,
    output logic [ADDR_W-1:0]          m_miss_block_address
);

    salc_cmd_t  cmd;
    salc_stat_t stat;

    salc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    salc_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_core               (s_core),
        .s_block_address      (s_block_address),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_miss_core          (m_miss_core),
        .m_miss_block_address (m_miss_block_address),
        .cmd                  (cmd),
        .stat                 (stat)
    );

    `SALC_ASSERT_NEXT(a_one_request_per_lookup, s_valid && s_ready, !s_ready)
    `SALC_ASSERT_SAME(a_result_after_lookup, $rose(m_valid), $past(!s_ready))
    `SALC_ASSERT_SAME(a_core_reduced, m_valid, int'(m_miss_core) < CORES)
    `SALC_ASSERT_SAME(a_no_load_during_clear, cmd.clear_we, !s_ready && !cmd.commit)

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the set-associative LRU cache filter
// Drives requests of core and block address, keeps a private copy of every
// core's tag store with valid bits and recency ranks, and checks each miss
// result that the block passes on against the oldest predicted miss.
// ----------------------------------------------------------------------------
module tb;
    import salc_pkg::*;

    localparam int ROWS_TOTAL      = CORES * SETS;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_REQUESTS = 1300;
    localparam int TAG_POOL        = 12;
    localparam int HOT_SETS        = 4;

    typedef struct {
        logic [IN_CORE_W-1:0] core;
        logic [ADDR_W-1:0]    addr;
    } miss_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [IN_CORE_W-1:0] s_core = '0;
    logic [ADDR_W-1:0]    s_block_address = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IN_CORE_W-1:0] m_miss_core;
    logic [ADDR_W-1:0]    m_miss_block_address;

    logic [ADDR_W-1:0] line_addr  [ROWS_TOTAL][WAYS];
    bit                line_valid [ROWS_TOTAL][WAYS];
    int                line_rank  [ROWS_TOTAL][WAYS];

    miss_t  pending_misses[$];
    int     errors = 0;
    int     requests = 0;
    int     misses = 0;
    int     results_seen = 0;
    bit     idling = 1'b1;
    longint cycles = 0;

    set_assoc_lru_cache_filter DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_core               (s_core),
        .s_block_address      (s_block_address),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_miss_core          (m_miss_core),
        .m_miss_block_address (m_miss_block_address)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_lines();
        for (int r = 0; r < ROWS_TOTAL; r++) begin
            for (int w = 0; w < WAYS; w++) begin
                line_addr[r][w]  = '0;
                line_valid[r][w] = 1'b0;
                line_rank[r][w]  = w;
            end
        end
    endfunction

    function automatic void make_most_recent(int row, int way);
        int old_rank;
        old_rank = line_rank[row][way];
        for (int j = 0; j < WAYS; j++) begin
            if (line_rank[row][j] < old_rank) begin
                line_rank[row][j]++;
            end
        end
        line_rank[row][way] = 0;
    endfunction

    // Returns 1 when the request misses; the miss is queued for checking.
    function automatic bit lookup_and_fill(logic [IN_CORE_W-1:0] c, logic [ADDR_W-1:0] a);
        int    core_red;
        int    row;
        int    fill_way;
        int    best;
        miss_t m;
        core_red = int'(c) % CORES;
        row = core_red * SETS + int'(a % ADDR_W'(SETS));
        for (int w = 0; w < WAYS; w++) begin
            if (line_valid[row][w] && line_addr[row][w] == a) begin
                make_most_recent(row, w);
                return 1'b0;
            end
        end
        fill_way = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (fill_way < 0 && !line_valid[row][w]) begin
                fill_way = w;
            end
        end
        if (fill_way < 0) begin
            best = 0;
            for (int w = 0; w < WAYS; w++) begin
                if (line_rank[row][w] >= best) begin
                    best = line_rank[row][w];
                    fill_way = w;
                end
            end
        end
        line_addr[row][fill_way]  = a;
        line_valid[row][fill_way] = 1'b1;
        make_most_recent(row, fill_way);
        m.core = IN_CORE_W'(core_red);
        m.addr = a;
        pending_misses.push_back(m);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idling) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    task automatic send_access(input logic [IN_CORE_W-1:0] c, input logic [ADDR_W-1:0] a);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_core          <= c;
        s_block_address <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests++;
        if (lookup_and_fill(c, a)) begin
            misses++;
        end
    endtask

    // Address 0 and the all-ones address must both miss when cold, then hit.
    task automatic test_cold_misses();
        send_access(IN_CORE_W'(0), '0);
        send_access(IN_CORE_W'(7), '1);
        send_access(IN_CORE_W'(0), '0);
        send_access(IN_CORE_W'(7), '1);
    endtask

    // Fills one set, refreshes the oldest way and forces LRU evictions.
    task automatic test_fill_and_evict();
        for (int k = 0; k < WAYS; k++) begin
            send_access(IN_CORE_W'(3), {TAG_W'(k + 1), SET_W'(5)});
        end
        send_access(IN_CORE_W'(3), {TAG_W'(1), SET_W'(5)});
        send_access(IN_CORE_W'(3), {TAG_W'(WAYS + 1), SET_W'(5)});
        send_access(IN_CORE_W'(3), {TAG_W'(2), SET_W'(5)});
        send_access(IN_CORE_W'(3), {TAG_W'(1), SET_W'(5)});
    endtask

    // The same address on every core misses once per private cache.
    task automatic test_private_per_core();
        for (int c = 0; c < 8; c++) begin
            send_access(IN_CORE_W'(c), {1'b1, (TAG_W - 1)'(0), SET_W'(5)});
        end
    endtask

    // Mostly a few hot sets with a small tag pool, so that hits and evictions
    // mix; the rest are fully random addresses.
    task automatic test_random_traffic();
        logic [TAG_W-1:0] tag_pool [TAG_POOL];
        logic [SET_W-1:0] hot_sets [HOT_SETS];
        logic [ADDR_W-1:0] a;
        int kind;
        for (int k = 0; k < TAG_POOL; k++) begin
            tag_pool[k] = TAG_W'({$urandom(), $urandom()});
        end
        for (int k = 0; k < HOT_SETS; k++) begin
            hot_sets[k] = SET_W'($urandom_range(0, SETS - 1));
        end
        idling = 1'b0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 200) begin
                idling = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                a = {tag_pool[$urandom_range(0, TAG_POOL - 1)],
                     hot_sets[$urandom_range(0, HOT_SETS - 1)]};
            end else begin
                a = {$urandom(), $urandom()};
            end
            send_access(IN_CORE_W'($urandom_range(0, 7)), a);
        end
    endtask

    initial begin
        wait (aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (idling) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        miss_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_misses.size() == 0) begin
                $display("%0t: unexpected miss result, core %0d address %h", $time,
                         m_miss_core, m_miss_block_address);
                errors++;
            end else begin
                want = pending_misses.pop_front();
                if (m_miss_core !== want.core) begin
                    $display("%0t: miss_core expected %0d actual %0d", $time,
                             want.core, m_miss_core);
                    errors++;
                end
                if (m_miss_block_address !== want.addr) begin
                    $display("%0t: miss_block_address expected %h actual %h", $time,
                             want.addr, m_miss_block_address);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        clear_lines();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_cold_misses();
        test_fill_and_evict();
        test_private_per_core();
        test_random_traffic();
        s_valid <= 1'b0;
        while (pending_misses.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d requests over all cores: %0d predicted misses, %0d hits.",
                 requests, misses, requests - misses);
        $display("Checked %0d miss results, with %0d mismatches.", results_seen, errors);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_ctrl.sv
rtl/salc_datapath.sv
rtl/set_assoc_lru_cache_filter.sv
test/tb.sv
